// ===== hw/rtl/aem_command_response_tracker_top_macros.svh =====
// Assertion macros used by the tracker top module.
`ifndef AEM_COMMAND_RESPONSE_TRACKER_TOP_MACROS_SVH
`define AEM_COMMAND_RESPONSE_TRACKER_TOP_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define AEM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define AEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hw/rtl/aem_pkg.sv =====
// ----------------------------------------------------------------------------
// AEM tracker package
// Shared types and codes of the command/response tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package aem_pkg;
	localparam logic [1:0] OP_CMD    = 2'd0;
	localparam logic [1:0] OP_RSP    = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] EV_STORED    = 3'd0;
	localparam logic [2:0] EV_MATCHED   = 3'd1;
	localparam logic [2:0] EV_UNMATCHED = 3'd2;
	localparam logic [2:0] EV_UNSOL     = 3'd3;
	localparam logic [2:0] EV_TIMEOUT   = 3'd4;
	localparam logic [2:0] EV_DROPPED   = 3'd5;

	localparam logic [23:0] TIMEOUT_RESET = 24'd250000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PSCAN,
		ST_PRES,
		ST_FSCAN,
		ST_FRES,
		ST_EMIT,
		ST_TSCAN,
		ST_TCHK,
		ST_TPAIR,
		ST_TPRES
	} state_t;

	// Key compare request from sequencer to comparator.
	typedef struct packed {
		logic [63:0] a_ctl;
		logic [63:0] a_tgt;
		logic [15:0] a_seq;
		logic [63:0] b_ctl;
		logic [63:0] b_tgt;
		logic [15:0] b_seq;
		logic        use_seq;
	} cmp_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/aem_command_response_tracker_top.sv =====
// ----------------------------------------------------------------------------
// AEM command/response tracker
// Correlates AEM commands and responses and keeps per pair counters.
// ----------------------------------------------------------------------------
// A command or solicited response keeps busy high through a pair scan and
// a flight scan: one table entry per cycle goes through the shared key
// comparator, and each scan stops at its first key match. An unsolicited
// response skips the flight scan. A tick scans the flight table for
// expired entries, with a pair scan and a result beat for each expiry.
// Results appear for one cycle with strobe high, one cycle after the
// sequencer emits them, and must be taken then; last_result marks the
// final one of an item.
`default_nettype none
`include "aem_command_response_tracker_top_macros.svh"
module aem_command_response_tracker_top #(
	parameter int FLIGHT_DEPTH = 16,
	parameter int PAIR_DEPTH   = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         cfg_we,
	input  wire  [23:0] cfg_wdata,
	input  wire  [1:0]  op,
	input  wire  [63:0] controller_id,
	input  wire  [63:0] target_id,
	input  wire  [15:0] seq_num,
	input  wire  [15:0] command_code,
	input  wire  [7:0]  status_code,
	input  wire         unsolicited,
	input  wire  [47:0] time_now,
	output logic        strobe,
	output logic [2:0]  event_kind,
	output logic [63:0] out_controller,
	output logic [63:0] out_target,
	output logic [15:0] out_sequence,
	output logic [15:0] out_command,
	output logic [7:0]  out_status,
	output logic [47:0] round_trip,
	output logic [31:0] pair_commands,
	output logic [31:0] pair_responses,
	output logic [31:0] pair_timeouts,
	output logic [31:0] pair_unsolicited,
	output logic        last_result
);
	import aem_pkg::*;

	localparam int FW = (FLIGHT_DEPTH > 1) ? $clog2(FLIGHT_DEPTH) : 1;
	localparam int PW = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
	localparam int FC = $clog2(FLIGHT_DEPTH + 1);
	localparam int PC = $clog2(PAIR_DEPTH + 1);

	// Tables: entries are read at a sequencer index, one per cycle during a key scan.
	logic [FLIGHT_DEPTH-1:0] fv_q;
	logic [63:0] fctl_q [FLIGHT_DEPTH];
	logic [63:0] ftgt_q [FLIGHT_DEPTH];
	logic [15:0] fseq_q [FLIGHT_DEPTH];
	logic [15:0] fcmd_q [FLIGHT_DEPTH];
	logic [47:0] ftime_q [FLIGHT_DEPTH];
	logic [PAIR_DEPTH-1:0] pv_q;
	logic [63:0] pctl_q [PAIR_DEPTH];
	logic [63:0] ptgt_q [PAIR_DEPTH];
	logic [31:0] pcc_q [PAIR_DEPTH];
	logic [31:0] prc_q [PAIR_DEPTH];
	logic [31:0] ptc_q [PAIR_DEPTH];
	logic [31:0] puc_q [PAIR_DEPTH];

	logic [23:0] tmo_q;
	state_t state_q, state_d;
	logic [1:0]  op_q;
	logic [63:0] ctl_q, tgt_q;
	logic [15:0] seq_q, cmd_q;
	logic [7:0]  st_q;
	logic        uns_q;
	logic [47:0] now_q;
	logic [FC-1:0] fi_q;
	logic [PC-1:0] pi_q;
	logic        phit_q, pfree_q, fhit_q, ffree_q;
	logic [PW-1:0] pslot_q, pfs_q;
	logic [FW-1:0] fslot_q, ffs_q;
	logic        pok_q;
	logic [FW-1:0] fidx, tidx_q;
	logic [PW-1:0] pidx;
	logic [48:0] dead_s1;

	cmp_req_t req;
	logic hit;
	aem_key_cmp u_cmp (.req(req), .hit(hit));

	assign fidx = fi_q[FW-1:0];
	assign pidx = pi_q[PW-1:0];

	// Comparator operands follow the scan in progress.
	always_comb begin
		req.b_ctl = ctl_q;
		req.b_tgt = tgt_q;
		req.b_seq = seq_q;
		req.a_ctl = fctl_q[fidx];
		req.a_tgt = ftgt_q[fidx];
		req.a_seq = fseq_q[fidx];
		req.use_seq = 1'b1;
		if (state_q == ST_PSCAN) begin
			req.a_ctl = pctl_q[pidx];
			req.a_tgt = ptgt_q[pidx];
			req.use_seq = 1'b0;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (op == OP_CMD || op == OP_RSP) state_d = ST_PSCAN;
					else if (op == OP_TICK) state_d = ST_TSCAN;
				end
			end
			ST_PSCAN: begin
				if (pi_q == PC'(PAIR_DEPTH - 1) || (pv_q[pidx] && hit)) state_d = ST_PRES;
			end
			ST_PRES: begin
				if (op_q == OP_TICK) state_d = ST_TPRES;
				else state_d = (op_q == OP_CMD || !uns_q) ? ST_FSCAN : ST_EMIT;
			end
			ST_FSCAN: begin
				if (fi_q == FC'(FLIGHT_DEPTH - 1) || (fv_q[fidx] && hit)) state_d = ST_FRES;
			end
			ST_FRES: state_d = ST_EMIT;
			ST_EMIT: state_d = (op_q == OP_TICK) ? ST_TSCAN : ST_IDLE;
			ST_TSCAN: begin
				if (fi_q == FC'(FLIGHT_DEPTH)) state_d = ST_IDLE;
				else state_d = ST_TCHK;
			end
			ST_TCHK: begin
				if (fv_q[fidx] && ({1'b0, now_q} > dead_s1)) state_d = ST_TPAIR;
				else state_d = ST_TSCAN;
			end
			ST_TPAIR: state_d = ST_PSCAN;
			ST_TPRES: state_d = ST_EMIT;
			default: state_d = ST_IDLE;
		endcase
	end

	// Whether any entry after the given index will still expire is not known
	// early, so a tick's last beat is found by a lookahead flag set on emit.
	logic more_exp;
	always_comb begin
		more_exp = 1'b0;
		for (int k = 0; k < FLIGHT_DEPTH; k++) begin
			if (k > int'(tidx_q) && fv_q[k] &&
				({1'b0, now_q} > ({1'b0, ftime_q[k]} + {25'd0, tmo_q})))
				more_exp = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fv_q <= '0;
			pv_q <= '0;
			tmo_q <= TIMEOUT_RESET;
			strobe <= 1'b0;
			fi_q <= '0;
			pi_q <= '0;
		end else begin
			state_q <= state_d;
			strobe <= (state_q == ST_EMIT);
			if (cfg_we) tmo_q <= cfg_wdata;
			unique case (state_q)
				ST_IDLE: begin
					op_q <= op; ctl_q <= controller_id; tgt_q <= target_id;
					seq_q <= seq_num; cmd_q <= command_code; st_q <= status_code;
					uns_q <= unsolicited; now_q <= time_now;
					pi_q <= '0; fi_q <= '0; phit_q <= 1'b0; pfree_q <= 1'b0;
					fhit_q <= 1'b0; ffree_q <= 1'b0;
				end
				ST_PSCAN: begin
					if (pv_q[pidx] && hit) begin
						phit_q <= 1'b1; pslot_q <= pidx;
					end else if (!pv_q[pidx] && !pfree_q) begin
						pfree_q <= 1'b1; pfs_q <= pidx;
					end
					pi_q <= pi_q + 1'b1;
				end
				ST_PRES, ST_TPRES: ;
				ST_FSCAN: begin
					if (fv_q[fidx] && hit) begin
						fhit_q <= 1'b1; fslot_q <= fidx;
					end else if (!fv_q[fidx] && !ffree_q) begin
						ffree_q <= 1'b1; ffs_q <= fidx;
					end
					fi_q <= fi_q + 1'b1;
				end
				ST_FRES: ;
				ST_EMIT: begin
					if (op_q == OP_TICK) fi_q <= fi_q + 1'b1;
				end
				ST_TSCAN: dead_s1 <= {1'b0, ftime_q[fidx]} + {25'd0, tmo_q};
				ST_TCHK: begin
					if (state_d == ST_TPAIR) begin
						ctl_q <= fctl_q[fidx]; tgt_q <= ftgt_q[fidx];
						seq_q <= fseq_q[fidx]; cmd_q <= fcmd_q[fidx];
						tidx_q <= fidx;
					end else fi_q <= fi_q + 1'b1;
				end
				ST_TPAIR: begin
					pi_q <= '0; phit_q <= 1'b0; pfree_q <= 1'b0;
				end
				default: ;
			endcase

			// Pair resolution: allocate and count.
			if (state_q == ST_PRES) begin
				logic [PW-1:0] ps;
				logic ok;
				ps = phit_q ? pslot_q : pfs_q;
				ok = phit_q || pfree_q;
				pok_q <= ok;
				pslot_q <= ps;
				if (ok) begin
					if (!phit_q) begin
						pv_q[ps] <= 1'b1; pctl_q[ps] <= ctl_q; ptgt_q[ps] <= tgt_q;
						pcc_q[ps] <= (op_q == OP_CMD) ? 32'd1 : 32'd0;
						prc_q[ps] <= (op_q == OP_RSP && !uns_q) ? 32'd1 : 32'd0;
						ptc_q[ps] <= (op_q == OP_TICK) ? 32'd1 : 32'd0;
						puc_q[ps] <= (op_q == OP_RSP && uns_q) ? 32'd1 : 32'd0;
					end else begin
						if (op_q == OP_CMD) pcc_q[ps] <= pcc_q[ps] + 32'd1;
						if (op_q == OP_RSP && !uns_q) prc_q[ps] <= prc_q[ps] + 32'd1;
						if (op_q == OP_TICK) ptc_q[ps] <= ptc_q[ps] + 32'd1;
						if (op_q == OP_RSP && uns_q) puc_q[ps] <= puc_q[ps] + 32'd1;
					end
				end
			end

			// Flight resolution: store or free.
			if (state_q == ST_FRES) begin
				if (op_q == OP_CMD) begin
					if (fhit_q || ffree_q) begin
						fv_q[fhit_q ? fslot_q : ffs_q] <= 1'b1;
						fctl_q[fhit_q ? fslot_q : ffs_q] <= ctl_q;
						ftgt_q[fhit_q ? fslot_q : ffs_q] <= tgt_q;
						fseq_q[fhit_q ? fslot_q : ffs_q] <= seq_q;
						fcmd_q[fhit_q ? fslot_q : ffs_q] <= cmd_q;
						ftime_q[fhit_q ? fslot_q : ffs_q] <= now_q;
					end
				end else if (fhit_q) fv_q[fslot_q] <= 1'b0;
			end

			// Result beat.
			if (state_q == ST_EMIT) begin
				out_controller <= ctl_q; out_target <= tgt_q; out_sequence <= seq_q;
				out_command <= cmd_q;
				out_status <= (op_q == OP_RSP) ? st_q : 8'd0;
				round_trip <= (op_q == OP_RSP && !uns_q && fhit_q &&
					now_q >= ftime_q[fslot_q]) ? now_q - ftime_q[fslot_q] : 48'd0;
				last_result <= (op_q == OP_TICK) ? !more_exp : 1'b1;
				if (op_q == OP_CMD) event_kind <= (fhit_q || ffree_q) ? EV_STORED : EV_DROPPED;
				else if (op_q == OP_TICK) begin
					event_kind <= EV_TIMEOUT;
					fv_q[tidx_q] <= 1'b0;
				end else if (uns_q) event_kind <= EV_UNSOL;
				else if (fhit_q) event_kind <= EV_MATCHED;
				else event_kind <= EV_UNMATCHED;
				pair_commands <= pok_q ? pcc_q[pslot_q] : 32'd0;
				pair_responses <= pok_q ? prc_q[pslot_q] : 32'd0;
				pair_timeouts <= pok_q ? ptc_q[pslot_q] : 32'd0;
				pair_unsolicited <= pok_q ? puc_q[pslot_q] : 32'd0;
			end
		end
	end

	`AEM_ASSERT_IMP(a_strobe_busy, clk, arst_n, strobe && !last_result, busy, "mid-item beat while idle")
	`AEM_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy && (op != OP_UNUSED), busy, "item not taken")
	`AEM_ASSERT_NEXT(a_emit_strobe, clk, arst_n, state_q == ST_EMIT, strobe, "emit without beat")
endmodule
`default_nettype wire

// ===== hw/rtl/aem_key_cmp.sv =====
// ----------------------------------------------------------------------------
// AEM key comparator
// The shared compare unit: matches one stored key against the search key.
// ----------------------------------------------------------------------------
`default_nettype none
module aem_key_cmp (
	input  wire aem_pkg::cmp_req_t req,
	output logic                   hit
);
	import aem_pkg::*;

	// Pair keys skip the sequence field.
	always_comb begin
		hit = (req.a_ctl == req.b_ctl) && (req.a_tgt == req.b_tgt) &&
			(!req.use_seq || (req.a_seq == req.b_seq));
	end
endmodule
`default_nettype wire
